@@ rtl/yuv420_block_to_rgb565_top_macros.svh @@
// Assertion macros for the YUV 4:2:0 to RGB565 converter.
// Needs a clock named clk and an active-low reset named arst_n in the using module.
`ifndef YUV420_BLOCK_TO_RGB565_TOP_MACROS_SVH
`define YUV420_BLOCK_TO_RGB565_TOP_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define YBR_ASSERT_SAME(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("yuv420_block_to_rgb565: same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define YBR_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("yuv420_block_to_rgb565: next-cycle check failed");

`endif

@@ rtl/yuv2rgb_pkg.sv @@
// Types, constant chroma tables and pixel helpers for the YUV 4:2:0 to RGB565 converter.
// Depends on nothing; used by yuv420_block_to_rgb565_top.
`timescale 1ns / 1ps
`default_nettype none

package yuv2rgb_pkg;

	localparam int SAMPLE_W = 8;
	localparam int PAIR_W   = 32;
	localparam int TERM_W   = 9;   // Chroma terms span -226..225.
	localparam int SUM_W    = 10;  // Luma plus a term spans -226..480.
	localparam int NUM_PIX  = 4;
	localparam int TBL_N    = 256;

	typedef logic [SAMPLE_W-1:0]      sample_t;
	typedef logic [PAIR_W-1:0]        pair_t;
	typedef logic signed [TERM_W-1:0] term_t;
	typedef logic signed [SUM_W-1:0]  sum_t;
	typedef term_t                    term_tbl_t [TBL_N];

	// Each table is indexed by the raw chroma sample; the centred value is index minus 128.
	// Integer division truncates toward zero, as the conversion requires.
	function automatic term_tbl_t build_ub();
		term_tbl_t t;
		int        c;
		for (int i = 0; i < TBL_N; i++) begin
			c    = i - 128;
			t[i] = TERM_W'((1772 * c) / 1000);
		end
		return t;
	endfunction

	function automatic term_tbl_t build_ug();
		term_tbl_t t;
		int        c;
		for (int i = 0; i < TBL_N; i++) begin
			c    = i - 128;
			t[i] = TERM_W'((34414 * c) / 100000);
		end
		return t;
	endfunction

	function automatic term_tbl_t build_vg();
		term_tbl_t t;
		int        c;
		for (int i = 0; i < TBL_N; i++) begin
			c    = i - 128;
			t[i] = TERM_W'((71414 * c) / 100000);
		end
		return t;
	endfunction

	function automatic term_tbl_t build_vr();
		term_tbl_t t;
		int        c;
		for (int i = 0; i < TBL_N; i++) begin
			c    = i - 128;
			t[i] = TERM_W'((1402 * c) / 1000);
		end
		return t;
	endfunction

	localparam term_tbl_t UB_TBL = build_ub();
	localparam term_tbl_t UG_TBL = build_ug();
	localparam term_tbl_t VG_TBL = build_vg();
	localparam term_tbl_t VR_TBL = build_vr();

	function automatic sample_t clamp_u8(input sum_t x);
		sample_t r;
		if (x < 0) begin
			r = '0;
		end else if (x > sum_t'(255)) begin
			r = '1;
		end else begin
			r = x[SAMPLE_W-1:0];
		end
		return r;
	endfunction

	function automatic logic [15:0] pack565(input sum_t r, input sum_t g, input sum_t b);
		sample_t rc;
		sample_t gc;
		sample_t bc;
		rc = clamp_u8(r);
		gc = clamp_u8(g);
		bc = clamp_u8(b);
		return {rc[7:3], gc[7:2], bc[7:3]};
	endfunction

	// Widens a luma sample to the signed sum width.
	function automatic sum_t luma_ext(input sample_t y);
		return sum_t'({2'b00, y});
	endfunction

	// Sign-extends a chroma term to the signed sum width.
	function automatic sum_t term_ext(input term_t t);
		return sum_t'({t[TERM_W-1], t});
	endfunction

endpackage

`default_nettype wire

@@ rtl/yuv420_block_to_rgb565_top.sv @@
// Converts one 2x2 YUV 4:2:0 block per transaction into two RGB565 row words. A new block can be
// accepted every cycle unless a stalled output has filled every stage: the three register stages
// (chroma table lookup, per-pixel sums, clamp and pack) each hold one block. A stalled output
// stalls only the stages that are full, so bubbles are squeezed out while the consumer waits.
// Depends on yuv2rgb_pkg and the macros header.
`timescale 1ns / 1ps
`default_nettype none
`include "yuv420_block_to_rgb565_top_macros.svh"

module yuv420_block_to_rgb565_top (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 item_valid,
	output logic                      item_ready,
	input  wire yuv2rgb_pkg::sample_t luma_top_left,
	input  wire yuv2rgb_pkg::sample_t luma_top_right,
	input  wire yuv2rgb_pkg::sample_t luma_bottom_left,
	input  wire yuv2rgb_pkg::sample_t luma_bottom_right,
	input  wire yuv2rgb_pkg::sample_t chroma_blue,
	input  wire yuv2rgb_pkg::sample_t chroma_red,
	output logic                      result_valid,
	input  wire logic                 result_ready,
	output yuv2rgb_pkg::pair_t        upper_pair,
	output yuv2rgb_pkg::pair_t        lower_pair
);
	import yuv2rgb_pkg::*;

	// Pixel order inside a block: top left, top right, bottom left, bottom right.
	logic    vld_s1, vld_s2, vld_s3;
	logic    adv_s1, adv_s2, adv_s3;

	sample_t luma_s1 [NUM_PIX];
	term_t   ub_s1, gsub_s1, vr_s1;

	sum_t    red_s2 [NUM_PIX];
	sum_t    grn_s2 [NUM_PIX];
	sum_t    blu_s2 [NUM_PIX];

	pair_t   upper_s3, lower_s3;

	// A stage may load when it is empty or when its contents move on this cycle.
	assign adv_s3     = !vld_s3 || result_ready;
	assign adv_s2     = !vld_s2 || adv_s3;
	assign adv_s1     = !vld_s1 || adv_s2;
	assign item_ready = adv_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
		end else begin
			if (adv_s1) vld_s1 <= item_valid;
			if (adv_s2) vld_s2 <= vld_s1;
			if (adv_s3) vld_s3 <= vld_s2;
		end
	end

	// Stage 1: chroma terms from the constant tables; the two green terms are merged here.
	always_ff @(posedge clk) begin
		if (adv_s1 && item_valid) begin
			luma_s1[0] <= luma_top_left;
			luma_s1[1] <= luma_top_right;
			luma_s1[2] <= luma_bottom_left;
			luma_s1[3] <= luma_bottom_right;
			ub_s1      <= UB_TBL[chroma_blue];
			gsub_s1    <= UG_TBL[chroma_blue] + VG_TBL[chroma_red];
			vr_s1      <= VR_TBL[chroma_red];
		end
	end

	// Stage 2: unclamped color sums for each pixel.
	always_ff @(posedge clk) begin
		if (adv_s2 && vld_s1) begin
			for (int p = 0; p < NUM_PIX; p++) begin
				red_s2[p] <= luma_ext(luma_s1[p]) + term_ext(vr_s1);
				grn_s2[p] <= luma_ext(luma_s1[p]) - term_ext(gsub_s1);
				blu_s2[p] <= luma_ext(luma_s1[p]) + term_ext(ub_s1);
			end
		end
	end

	// Stage 3: clamp, pack and form the row words (left pixel in the low half).
	always_ff @(posedge clk) begin
		if (adv_s3 && vld_s2) begin
			upper_s3 <= {pack565(red_s2[1], grn_s2[1], blu_s2[1]),
			             pack565(red_s2[0], grn_s2[0], blu_s2[0])};
			lower_s3 <= {pack565(red_s2[3], grn_s2[3], blu_s2[3]),
			             pack565(red_s2[2], grn_s2[2], blu_s2[2])};
		end
	end

	assign result_valid = vld_s3;
	assign upper_pair   = upper_s3;
	assign lower_pair   = lower_s3;

	// Back-pressure only reaches the input when every stage is occupied.
	`YBR_ASSERT_SAME(a_ready_only_when_full, !item_ready, vld_s1 && vld_s2 && vld_s3)
	// An accepted transaction always lands in the first stage.
	`YBR_ASSERT_NEXT(a_accept_fills_s1, item_valid && item_ready, vld_s1)
	// A stage 2 block that cannot move keeps its sums.
	`YBR_ASSERT_NEXT(a_s2_holds_on_stall, vld_s2 && vld_s3 && !result_ready,
		vld_s2 && $stable(red_s2[0]) && $stable(grn_s2[3]) && $stable(blu_s2[1]))
	// A taken result with nothing behind it leaves the output empty.
	`YBR_ASSERT_NEXT(a_drain_empties, result_valid && result_ready && !vld_s2, !result_valid)

endmodule

`default_nettype wire

@@ verif/tb.sv @@
// Self-checking testbench for yuv420_block_to_rgb565_top: directed blocks, then random blocks,
// each checked against hand-worked rows or a behavioral color-space converter. Depends on yuv2rgb_pkg and the RTL.
`timescale 1ns / 1ps

module tb;
	import yuv2rgb_pkg::*;

	localparam int DIR_N      = 20;
	localparam int RANDOM_N   = 1100;
	localparam int CALM_TAIL  = 150;   // Final random blocks sent with no idling on either side.

	typedef struct packed {
		sample_t ytl;
		sample_t ytr;
		sample_t ybl;
		sample_t ybr;
		sample_t cb;
		sample_t cr;
	} block_t;

	typedef struct packed {
		pair_t upper;
		pair_t lower;
	} rgb_rows_t;

	typedef struct packed {
		block_t    blk;
		bit        known;
		rgb_rows_t rows;
	} dir_row_t;

	// Rows marked known carry the packed result worked out by hand; the rest use the converter.
	localparam dir_row_t DIRECTED_ROWS [DIR_N] = '{
		'{'{8'h00, 8'h00, 8'h00, 8'h00, 8'h80, 8'h80}, 1'b1, '{32'h0000_0000, 32'h0000_0000}},
		'{'{8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'h80, 8'h80}, 1'b1, '{32'hFFFF_FFFF, 32'hFFFF_FFFF}},
		'{'{8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF}, 1'b1, '{32'hFBDF_FBDF, 32'hFBDF_FBDF}},
		'{'{8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00}, 1'b1, '{32'h0420_0420, 32'h0420_0420}},
		'{'{8'h00, 8'h55, 8'hAA, 8'hFF, 8'h80, 8'h80}, 1'b0, '0},
		'{'{8'hFF, 8'hAA, 8'h55, 8'h00, 8'h80, 8'h80}, 1'b0, '0},
		'{'{8'h80, 8'h80, 8'h80, 8'h80, 8'h00, 8'hFF}, 1'b0, '0},
		'{'{8'h80, 8'h80, 8'h80, 8'h80, 8'hFF, 8'h00}, 1'b0, '0},
		'{'{8'h80, 8'h80, 8'h80, 8'h80, 8'h7F, 8'h81}, 1'b0, '0},
		'{'{8'h80, 8'h80, 8'h80, 8'h80, 8'h81, 8'h7F}, 1'b0, '0},
		'{'{8'h40, 8'hC0, 8'h10, 8'hF0, 8'h7E, 8'h82}, 1'b0, '0},
		'{'{8'h00, 8'h00, 8'h00, 8'h00, 8'hFF, 8'h80}, 1'b0, '0},
		'{'{8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'h00, 8'h80}, 1'b0, '0},
		'{'{8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'h80, 8'h00}, 1'b0, '0},
		'{'{8'h00, 8'hFF, 8'h00, 8'hFF, 8'h80, 8'hFF}, 1'b0, '0},
		'{'{8'h10, 8'hEB, 8'h10, 8'hEB, 8'h10, 8'hF0}, 1'b0, '0},
		'{'{8'hAA, 8'h55, 8'hAA, 8'h55, 8'hAA, 8'h55}, 1'b0, '0},
		'{'{8'h55, 8'hAA, 8'h55, 8'hAA, 8'h55, 8'hAA}, 1'b0, '0},
		'{'{8'h01, 8'hFE, 8'h07, 8'hF8, 8'h04, 8'hFC}, 1'b0, '0},
		'{'{8'h08, 8'h04, 8'h03, 8'hFC, 8'h80, 8'h80}, 1'b0, '0}
	};

	logic    clk               = 1'b0;
	logic    arst_n            = 1'b0;
	logic    item_valid        = 1'b0;
	logic    item_ready;
	sample_t luma_top_left     = '0;
	sample_t luma_top_right    = '0;
	sample_t luma_bottom_left  = '0;
	sample_t luma_bottom_right = '0;
	sample_t chroma_blue       = '0;
	sample_t chroma_red        = '0;
	logic    result_valid;
	logic    result_ready      = 1'b0;
	pair_t   upper_pair;
	pair_t   lower_pair;

	rgb_rows_t rgb_due [$];
	int        mismatches  = 0;
	int        stall_left  = 0;
	bit        idle_enable = 1'b1;

	yuv420_block_to_rgb565_top dut (
		.clk               (clk),
		.arst_n            (arst_n),
		.item_valid        (item_valid),
		.item_ready        (item_ready),
		.luma_top_left     (luma_top_left),
		.luma_top_right    (luma_top_right),
		.luma_bottom_left  (luma_bottom_left),
		.luma_bottom_right (luma_bottom_right),
		.chroma_blue       (chroma_blue),
		.chroma_red        (chroma_red),
		.result_valid      (result_valid),
		.result_ready      (result_ready),
		.upper_pair        (upper_pair),
		.lower_pair        (lower_pair)
	);

	always #5 clk = ~clk;

	function automatic logic [7:0] sat8(input int x);
		logic [7:0] r;
		if (x < 0) begin
			r = 8'd0;
		end else if (x > 255) begin
			r = 8'd255;
		end else begin
			r = 8'(x);
		end
		return r;
	endfunction

	function automatic logic [15:0] rgb565(input sample_t y, input int b_off, input int g_off,
			input int r_off);
		logic [7:0] r;
		logic [7:0] g;
		logic [7:0] b;
		r = sat8(int'(y) + r_off);
		g = sat8(int'(y) - g_off);
		b = sat8(int'(y) + b_off);
		return {r[7:3], g[7:2], b[7:3]};
	endfunction

	// Chroma terms use integer division, which truncates toward zero just like the hardware tables.
	function automatic rgb_rows_t convert_block(input block_t blk);
		int        u;
		int        v;
		int        b_off;
		int        g_off;
		int        r_off;
		rgb_rows_t rows;
		u     = int'(blk.cb) - 128;
		v     = int'(blk.cr) - 128;
		b_off = (1772 * u) / 1000;
		g_off = (34414 * u) / 100000 + (71414 * v) / 100000;
		r_off = (1402 * v) / 1000;
		rows.upper = {rgb565(blk.ytr, b_off, g_off, r_off), rgb565(blk.ytl, b_off, g_off, r_off)};
		rows.lower = {rgb565(blk.ybr, b_off, g_off, r_off), rgb565(blk.ybl, b_off, g_off, r_off)};
		return rows;
	endfunction

	function automatic sample_t pick_sample(input bit chroma);
		sample_t s;
		case ($urandom_range(0, 9))
			0: begin
				s = 8'h00;
			end
			1: begin
				s = 8'hFF;
			end
			2: begin
				s = chroma ? 8'($urandom_range(120, 136)) : 8'($urandom_range(0, 255));
			end
			default: begin
				s = 8'($urandom_range(0, 255));
			end
		endcase
		return s;
	endfunction

	task automatic report_mismatch(input string msg);
		$display("[%0t] MISMATCH %s", $time, msg);
		mismatches++;
	endtask

	// Presents one block and records its expected rows once the transaction is accepted.
	task automatic send_block(input block_t blk, input bit known, input rgb_rows_t hand_rows);
		if (idle_enable && $urandom_range(0, 7) == 0) begin
			item_valid <= 1'b0;
			repeat ($urandom_range(1, 13)) @(posedge clk);
		end
		luma_top_left     <= blk.ytl;
		luma_top_right    <= blk.ytr;
		luma_bottom_left  <= blk.ybl;
		luma_bottom_right <= blk.ybr;
		chroma_blue       <= blk.cb;
		chroma_red        <= blk.cr;
		item_valid        <= 1'b1;
		do @(posedge clk); while (!item_ready);
		rgb_due.push_back(known ? hand_rows : convert_block(blk));
	endtask

	task automatic drain_pipeline();
		item_valid <= 1'b0;
		do @(posedge clk); while (rgb_due.size() != 0);
	endtask

	initial begin
		block_t blk;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		foreach (DIRECTED_ROWS[i]) begin
			send_block(DIRECTED_ROWS[i].blk, DIRECTED_ROWS[i].known, DIRECTED_ROWS[i].rows);
		end
		drain_pipeline();
		for (int i = 0; i < RANDOM_N; i++) begin
			// Alternate stretches with and without idling, then keep the tail free of it.
			idle_enable = (i < RANDOM_N - CALM_TAIL) && ((i / 100) % 3 != 2);
			if (i == RANDOM_N / 2) begin
				drain_pipeline();
			end
			blk.ytl = pick_sample(1'b0);
			blk.ytr = pick_sample(1'b0);
			blk.ybl = pick_sample(1'b0);
			blk.ybr = pick_sample(1'b0);
			blk.cb  = pick_sample(1'b1);
			blk.cr  = pick_sample(1'b1);
			send_block(blk, 1'b0, '0);
		end
		item_valid <= 1'b0;
		while (rgb_due.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
		if (mismatches == 0) begin
			$display("end of test: clean");
		end else begin
			$display("end of test: mismatches");
		end
		$finish;
	end

	// Output side back-pressure: stalls of random length start at random while idling is allowed.
	always @(posedge clk) begin
		if (stall_left != 0) begin
			stall_left   <= stall_left - 1;
			result_ready <= 1'b0;
		end else if (idle_enable && $urandom_range(0, 9) == 0) begin
			stall_left   <= $urandom_range(0, 12);
			result_ready <= 1'b0;
		end else begin
			result_ready <= 1'b1;
		end
	end

	always @(posedge clk) begin
		rgb_rows_t want;
		if (arst_n && result_valid && result_ready) begin
			if (rgb_due.size() == 0) begin
				report_mismatch($sformatf("result with nothing outstanding: upper %h lower %h",
					upper_pair, lower_pair));
			end else begin
				want = rgb_due.pop_front();
				if (upper_pair !== want.upper) begin
					report_mismatch($sformatf("upper_pair got %h want %h", upper_pair, want.upper));
				end
				if (lower_pair !== want.lower) begin
					report_mismatch($sformatf("lower_pair got %h want %h", lower_pair, want.lower));
				end
			end
		end
	end

	initial begin
		#2_000_000;
		$display("[%0t] timeout with %0d results outstanding", $time, rgb_due.size());
		$display("end of test: mismatches");
		$finish;
	end

endmodule
